/* hw/rtl/vertex_affine_transform_assert.svh */
// Assertion macros for the vertex transform port checker.
`ifndef VERTEX_AFFINE_TRANSFORM_ASSERT_SVH
`define VERTEX_AFFINE_TRANSFORM_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define VAT_ASSERT_IMPLY(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("vertex transform: port check failed");

// Implication whose consequent is checked in the cycle after the antecedent
`define VAT_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("vertex transform: port check failed");

// Implication checked on every clock edge, reset included
`define VAT_ASSERT_ALWAYS(lbl, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |-> (post)) \
    else $error("vertex transform: port check failed");

`endif

/* hw/rtl/vat_pkg.sv */
// Shared types, constants and coefficient helpers for the vertex transform.
package vat_pkg;

  localparam int DATA_W        = 32;
  localparam int CFG_W         = 64;
  localparam int CFG_REGS      = 8;
  localparam int CFG_IDX_W     = 4;
  localparam int CFG_SEL_W     = 3;
  localparam int IN_ROWS       = 3;
  localparam int COLS          = 4;
  localparam int PROD_W        = 2 * DATA_W;
  localparam int S_TDATA_W     = 3 * DATA_W;
  localparam int M_TDATA_W     = 4 * DATA_W;
  localparam int FRAC_BITS_DEF = 16;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS01 = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS23 = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS01 = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS23 = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS01 = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS23 = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3_COLS01 = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3_COLS23 = 4'd7;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT       = 4'd8;

  typedef logic [CFG_REGS-1:0][CFG_W-1:0] vat_cfg_bank_t;
  typedef logic [IN_ROWS-1:0][COLS-1:0][PROD_W-1:0] vat_prod_bank_t;

  // Reset gives the identity matrix
  localparam vat_cfg_bank_t CFG_RESET = {
    64'h0001_0000_0000_0000,  // row 3, columns 2 and 3
    64'h0000_0000_0000_0000,  // row 3, columns 0 and 1
    64'h0000_0000_0001_0000,  // row 2, columns 2 and 3
    64'h0000_0000_0000_0000,  // row 2, columns 0 and 1
    64'h0000_0000_0000_0000,  // row 1, columns 2 and 3
    64'h0001_0000_0000_0000,  // row 1, columns 0 and 1
    64'h0000_0000_0000_0000,  // row 0, columns 2 and 3
    64'h0000_0000_0001_0000   // row 0, columns 0 and 1
  };

  // Pipeline advance enables, output stage last
  typedef struct packed {
    logic en_in;
    logic en_mul;
    logic en_sum;
    logic en_out;
  } vat_stall_t;

  // Pick matrix element M[row][col] out of the register bank
  function automatic logic signed [DATA_W-1:0] coef(input vat_cfg_bank_t bank,
                                                    input int row, input int col);
    logic [CFG_W-1:0] word;
    word = bank[row * 2 + col / 2];
    return (col % 2 == 1) ? $signed(word[CFG_W-1:DATA_W]) : $signed(word[DATA_W-1:0]);
  endfunction

endpackage

/* hw/rtl/vat_cfg_regs.sv */
// Matrix register bank written over the configuration channel.
module vat_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic [vat_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vat_pkg::CFG_W-1:0]        cfg_data,
  output vat_pkg::vat_cfg_bank_t           bank
);
  import vat_pkg::*;

  // Load identity on reset, take writes that fall inside the list
  always_ff @(posedge clk) begin
    if (rst) begin
      bank <= CFG_RESET;
    end else if (cfg_valid && (cfg_index < REG_COUNT)) begin
      bank[cfg_index[CFG_SEL_W-1:0]] <= cfg_data;
    end
  end

endmodule

/* hw/rtl/vat_mul_array.sv */
// Input register and the twelve coordinate-by-coefficient products.
module vat_mul_array (
  input  logic                             clk,
  input  vat_pkg::vat_stall_t              stall,
  input  logic [vat_pkg::S_TDATA_W-1:0]    coord,
  input  vat_pkg::vat_cfg_bank_t           bank,
  output vat_pkg::vat_prod_bank_t          prod
);
  import vat_pkg::*;

  logic [IN_ROWS-1:0][DATA_W-1:0] vec;

  // Capture the incoming vertex
  always_ff @(posedge clk) begin
    if (stall.en_in) begin
      vec <= coord;
    end
  end

  // One 32x32 signed multiplier per element of matrix rows 0 to 2, registered
  for (genvar k = 0; k < IN_ROWS; k++) begin : g_row
    for (genvar j = 0; j < COLS; j++) begin : g_col
      logic signed [PROD_W-1:0] prod_next;

      always_comb begin
        prod_next = $signed(vec[k]) * coef(bank, k, j);
      end

      always_ff @(posedge clk) begin
        if (stall.en_mul) begin
          prod[k][j] <= prod_next;
        end
      end
    end
  end

endmodule

/* hw/rtl/vat_col_reduce.sv */
// One output column: sum of three products, then floor shift, translation and clamp.
module vat_col_reduce #(
  parameter int FRAC_BITS = vat_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  vat_pkg::vat_stall_t              stall,
  input  logic [vat_pkg::PROD_W-1:0]       prod0,
  input  logic [vat_pkg::PROD_W-1:0]       prod1,
  input  logic [vat_pkg::PROD_W-1:0]       prod2,
  input  logic                             add_tr,
  input  logic signed [vat_pkg::DATA_W-1:0] trans,
  output logic [vat_pkg::DATA_W-1:0]       result
);
  import vat_pkg::*;

  localparam int SUM_W = PROD_W + 2;
  localparam int SH_W  = SUM_W - FRAC_BITS;
  localparam int T_W   = SH_W + 1;

  localparam logic signed [T_W-1:0] SAT_MAX =
    {{(T_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
  localparam logic signed [T_W-1:0] SAT_MIN =
    {{(T_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};

  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  sum_next;
  logic signed [T_W-1:0]    total;
  logic signed [T_W-1:0]    trans_ext;
  logic [DATA_W-1:0]        result_next;

  // Exact sum of the three products
  always_comb begin
    sum_next = $signed({{2{prod0[PROD_W-1]}}, prod0})
             + $signed({{2{prod1[PROD_W-1]}}, prod1})
             + $signed({{2{prod2[PROD_W-1]}}, prod2});
  end

  always_ff @(posedge clk) begin
    if (stall.en_sum) begin
      sum <= sum_next;
    end
  end

  // Drop fraction bits (floor), add translation when add_tr is set, clamp to 32 bits
  always_comb begin
    trans_ext = add_tr ? $signed({{(T_W - DATA_W){trans[DATA_W-1]}}, trans}) : '0;
    total     = $signed({sum[SUM_W-1], sum[SUM_W-1:FRAC_BITS]}) + trans_ext;
    if (total > SAT_MAX) begin
      result_next = SAT_MAX[DATA_W-1:0];
    end else if (total < SAT_MIN) begin
      result_next = SAT_MIN[DATA_W-1:0];
    end else begin
      result_next = total[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (stall.en_out) begin
      result <= result_next;
    end
  end

endmodule

/* hw/rtl/vertex_affine_transform.sv */
// Affine transform of streamed vertices by a configurable 4x4 matrix, top level.
// Each word in carries a Q16.16 vertex (x, y, z); the block returns
// (x, y, z) * rows 0..2 of the matrix, plus row 3 when tuser is set, as four
// Q16.16 components floored and clamped to 32 bits, with tlast passed along.
// A new vertex is accepted every cycle while m_tready is high; each vertex
// passes through the input register, the multiplier array, the column adder
// and the shift/clamp register. Empty stages are filled while the output is
// held, and s_tready is high whenever m_tready is. cfg_ready is tied high.
// Configuration writes must only be issued while the pipeline is empty.
module vertex_affine_transform #(
  parameter int FRAC_BITS = vat_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Vertex stream in
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [vat_pkg::S_TDATA_W-1:0]     s_tdata,   // x_in, y_in, z_in
  input  logic                              s_tuser,   // add_translation
  input  logic                              s_tlast,   // last_vertex_in
  // Transformed stream out
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [vat_pkg::M_TDATA_W-1:0]     m_tdata,   // x_out, y_out, z_out, w_out
  output logic                              m_tlast,   // last_vertex_out
  // Matrix configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [vat_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vat_pkg::CFG_W-1:0]         cfg_data
);
  import vat_pkg::*;

  vat_stall_t          stall;
  vat_cfg_bank_t       bank;
  vat_prod_bank_t      prod;
  logic [3:0]          vld;
  logic [2:0]          tr_pipe;
  logic [3:0]          last_pipe;
  logic [COLS-1:0][DATA_W-1:0] col_res;

  assign cfg_ready = 1'b1;

  // Advance each stage when it is empty or the next one moves
  always_comb begin
    stall.en_out = !vld[3] || m_tready;
    stall.en_sum = !vld[2] || stall.en_out;
    stall.en_mul = !vld[1] || stall.en_sum;
    stall.en_in  = !vld[0] || stall.en_mul;
  end

  assign s_tready = stall.en_in;

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (stall.en_in)  vld[0] <= s_tvalid;
      if (stall.en_mul) vld[1] <= vld[0];
      if (stall.en_sum) vld[2] <= vld[1];
      if (stall.en_out) vld[3] <= vld[2];
    end
  end

  // Side-band flags follow the vertex
  always_ff @(posedge clk) begin
    if (stall.en_in) begin
      tr_pipe[0]   <= s_tuser;
      last_pipe[0] <= s_tlast;
    end
    if (stall.en_mul) begin
      tr_pipe[1]   <= tr_pipe[0];
      last_pipe[1] <= last_pipe[0];
    end
    if (stall.en_sum) begin
      tr_pipe[2]   <= tr_pipe[1];
      last_pipe[2] <= last_pipe[1];
    end
    if (stall.en_out) begin
      last_pipe[3] <= last_pipe[2];
    end
  end

  vat_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .bank      (bank)
  );

  vat_mul_array u_mul (
    .clk   (clk),
    .stall (stall),
    .coord (s_tdata),
    .bank  (bank),
    .prod  (prod)
  );

  for (genvar j = 0; j < COLS; j++) begin : g_col
    vat_col_reduce #(
      .FRAC_BITS (FRAC_BITS)
    ) u_col (
      .clk    (clk),
      .stall  (stall),
      .prod0  (prod[0][j]),
      .prod1  (prod[1][j]),
      .prod2  (prod[2][j]),
      .add_tr (tr_pipe[2]),
      .trans  (coef(bank, 3, j)),
      .result (col_res[j])
    );
  end

  assign m_tvalid = vld[3];
  assign m_tdata  = col_res;
  assign m_tlast  = last_pipe[3];

endmodule

/* hw/rtl/vat_port_checker.sv */
// Port-level checks for the vertex transform, bound to the top level.
`include "vertex_affine_transform_assert.svh"

module vat_port_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [vat_pkg::M_TDATA_W-1:0]    m_tdata,
  input logic                             m_tlast
);
  import vat_pkg::*;

  // Hold a stalled output word
  `VAT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
  `VAT_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))
  // Drop all words in flight on reset, seen at the first edge after release
  `VAT_ASSERT_ALWAYS(a_reset_empty, $past(rst) && !rst, !m_tvalid)
  // Accept input whenever the output side is draining
  `VAT_ASSERT_IMPLY(a_flow_through, m_tready, s_tready)

endmodule

bind vertex_affine_transform vat_port_checker u_port_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
